@@ src/ntw_pkg.sv @@
// ----------------------------------------------------------------------------
// ntw_pkg
// Types and constants shared by the number-to-word-token blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ntw_pkg;

  localparam int unsigned ValueW      = 40;
  localparam int unsigned WordW       = 5;
  localparam int unsigned SepW        = 2;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned NumDigits   = 12;
  localparam int unsigned BcdW        = NumDigits * DigitW;
  localparam int unsigned NumGroups   = 4;
  localparam int unsigned TokPerGroup = 5;
  localparam int unsigned NumTok      = NumGroups * TokPerGroup;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned ConvSteps   = ValueW / BitsPerStep;
  localparam int unsigned CntW        = $clog2(ConvSteps + 1);

  localparam logic [ValueW-1:0] MaxValue = 40'd999999999999;

  localparam logic [WordW-1:0] TokZero     = 5'd0;
  localparam logic [WordW-1:0] TokTen      = 5'd10;
  localparam logic [WordW-1:0] TokTensBase = 5'd18;
  localparam logic [WordW-1:0] TokHundred  = 5'd28;
  localparam logic [WordW-1:0] TokThousand = 5'd29;
  localparam logic [WordW-1:0] TokMillion  = 5'd30;
  localparam logic [WordW-1:0] TokBillion  = 5'd31;

  localparam logic [SepW-1:0] SepNone   = 2'd0;
  localparam logic [SepW-1:0] SepSpace  = 2'd1;
  localparam logic [SepW-1:0] SepHyphen = 2'd2;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    logic    err;
    digits_t digits;
  } item_t;

endpackage

`default_nettype wire

@@ src/ntw_front.sv @@
// ----------------------------------------------------------------------------
// ntw_front
// Accepts a number, range-checks it and converts it to twelve BCD digits,
// four bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ntw_front import ntw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output item_t                  push_item_o
);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] bin_q, bin_d, bin_n;
  logic [BcdW-1:0]   bcd_q, bcd_d, bcd_n;
  logic              err_q, err_d;
  logic              done;
  logic              accept;

  assign done         = busy_q && (cnt_q == '0);
  assign push_valid_o = done;
  assign in_ready_o   = !busy_q || (done && push_ready_i);
  assign accept       = in_valid_i && in_ready_o;

  assign push_item_o.err    = err_q;
  assign push_item_o.digits = bcd_q;

  always_comb begin
    bin_n = bin_q;
    bcd_n = bcd_q;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd_n[d*DigitW +: DigitW] >= 4'd5) begin
          bcd_n[d*DigitW +: DigitW] = bcd_n[d*DigitW +: DigitW] + 4'd3;
        end
      end
      bcd_n = {bcd_n[BcdW-2:0], bin_n[ValueW-1]};
      bin_n = {bin_n[ValueW-2:0], 1'b0};
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    err_d  = err_q;
    if (accept) begin
      busy_d = 1'b1;
      bin_d  = value_i;
      bcd_d  = '0;
      err_d  = value_i > MaxValue;
      cnt_d  = (value_i > MaxValue) ? '0 : CntW'(ConvSteps);
    end else if (done && push_ready_i) begin
      busy_d = 1'b0;
    end else if (busy_q && (cnt_q != '0)) begin
      bin_d = bin_n;
      bcd_d = bcd_n;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    err_q <= err_d;
  end

endmodule

`default_nettype wire

@@ src/ntw_fifo.sv @@
// ----------------------------------------------------------------------------
// ntw_fifo
// Short queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ntw_fifo import ntw_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW2 = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW2-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CntW2'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/ntw_back.sv @@
// ----------------------------------------------------------------------------
// ntw_back
// Walks a converted number's token slots; one word a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ntw_back import ntw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  wire item_t            pop_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WordW-1:0]      word_o,
  output logic [SepW-1:0]       separator_o,
  output logic                  range_error_o,
  output logic                  last_word_o
);

  logic              active_q, active_d;
  logic [NumTok-1:0] mask_q, mask_d;
  digits_t           digits_q, digits_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  word_q, word_d;
  logic [SepW-1:0]   sep_q, sep_d;
  logic              err_q, err_d;
  logic              last_q, last_d;

  digits_t           src_digits;
  logic [NumTok-1:0] full_mask, src_mask, pick, rest;
  logic [WordW-1:0]  tok_word [NumTok];
  logic [SepW-1:0]   tok_sep  [NumTok];
  logic [WordW-1:0]  sel_word;
  logic [SepW-1:0]   sel_sep;
  logic              adv;

  assign src_digits = active_q ? digits_q : pop_item_i.digits;

  for (genvar k = 0; k < NumGroups; k++) begin : g_group
    localparam int unsigned G = NumGroups - 1 - k;
    logic [DigitW-1:0] h, t, u;
    logic              nz;
    assign h  = src_digits[3*G+2];
    assign t  = src_digits[3*G+1];
    assign u  = src_digits[3*G];
    assign nz = (h != '0) || (t != '0) || (u != '0);

    assign full_mask[k*TokPerGroup+0] = h != '0;
    assign full_mask[k*TokPerGroup+1] = h != '0;
    assign full_mask[k*TokPerGroup+2] = (t != '0) || (u != '0);
    assign full_mask[k*TokPerGroup+3] = (t >= 4'd2) && (u != '0);
    assign full_mask[k*TokPerGroup+4] = nz && (G != 0);

    assign tok_word[k*TokPerGroup+0] = WordW'(h);
    assign tok_word[k*TokPerGroup+1] = TokHundred;
    assign tok_word[k*TokPerGroup+2] = (t >= 4'd2) ? TokTensBase + WordW'(t) :
                                       (t[0] ? TokTen + WordW'(u) : WordW'(u));
    assign tok_word[k*TokPerGroup+3] = WordW'(u);
    assign tok_word[k*TokPerGroup+4] = (G == 3) ? TokBillion :
                                       (G == 2) ? TokMillion : TokThousand;

    assign tok_sep[k*TokPerGroup+0] = SepSpace;
    assign tok_sep[k*TokPerGroup+1] = SepSpace;
    assign tok_sep[k*TokPerGroup+2] = SepSpace;
    assign tok_sep[k*TokPerGroup+3] = SepHyphen;
    assign tok_sep[k*TokPerGroup+4] = SepSpace;
  end

  assign src_mask = active_q ? mask_q : full_mask;
  assign pick     = src_mask & (~src_mask + 1'b1);
  assign rest     = src_mask & ~pick;

  always_comb begin
    sel_word = '0;
    sel_sep  = '0;
    for (int i = 0; i < NumTok; i++) begin
      sel_word = sel_word | (tok_word[i] & {WordW{pick[i]}});
      sel_sep  = sel_sep  | (tok_sep[i]  & {SepW{pick[i]}});
    end
  end

  assign adv         = !out_valid_q || out_ready_i;
  assign pop_ready_o = adv && !active_q;

  always_comb begin
    active_d    = active_q;
    mask_d      = mask_q;
    digits_d    = digits_q;
    out_valid_d = out_valid_q && !out_ready_i;
    word_d      = word_q;
    sep_d       = sep_q;
    err_d       = err_q;
    last_d      = last_q;
    if (adv) begin
      if (active_q) begin
        out_valid_d = 1'b1;
        word_d      = sel_word;
        sep_d       = sel_sep;
        err_d       = 1'b0;
        last_d      = rest == '0;
        mask_d      = rest;
        active_d    = rest != '0;
      end else if (pop_valid_i) begin
        out_valid_d = 1'b1;
        sep_d       = SepNone;
        if (pop_item_i.err) begin
          word_d = TokZero;
          err_d  = 1'b1;
          last_d = 1'b1;
        end else if (full_mask == '0) begin
          word_d = TokZero;
          err_d  = 1'b0;
          last_d = 1'b1;
        end else begin
          word_d   = sel_word;
          err_d    = 1'b0;
          last_d   = rest == '0;
          mask_d   = rest;
          digits_d = pop_item_i.digits;
          active_d = rest != '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q   <= mask_d;
    digits_q <= digits_d;
    word_q   <= word_d;
    sep_q    <= sep_d;
    err_q    <= err_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign word_o        = word_q;
  assign separator_o   = sep_q;
  assign range_error_o = err_q;
  assign last_word_o   = last_q;

endmodule

`default_nettype wire

@@ src/number_to_word_tokens.sv @@
// ----------------------------------------------------------------------------
// number_to_word_tokens
// Reads an unsigned number below one trillion as a stream of English word
// tokens.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   input   | in_valid_i/in_ready_o | value_i[39:0]
//   output  | out_valid_o/out_ready_i | word_o[4:0], separator_o[1:0],
//           |                       | range_error_o, last_word_o
//
// The front converts a number 4 bits a cycle and takes the next number only
// as it hands the last one to the queue; an out-of-range number skips the
// conversion. The back issues one word per cycle while out_ready_i is high,
// up to 19 words per number.
// Reset clears all control state at once; no clearing pass.
// Either side stalls on its own through the queue between them.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_word_tokens import ntw_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       word_o,
  output logic [SepW-1:0]        separator_o,
  output logic                   range_error_o,
  output logic                   last_word_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  ntw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  ntw_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ntw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_o        (word_o),
    .separator_o   (separator_o),
    .range_error_o (range_error_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire

@@ sim/number_to_word_tokens_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// number_to_word_tokens_test
// Feeds numbers into number_to_word_tokens and checks every word it reads out.
// A scoreboard predicts the words of each accepted number (groups of three
// digits, hundreds, tens joined by a hyphen to units, scale words, zero and
// the out-of-range error) and compares each accepted word in order. Directed
// numbers come first, then random ones, mostly built group by group. Both
// sides idle at random; the receiver also holds off for a long stretch so
// that the block backs up, and the sender once waits for all words to drain.
// ----------------------------------------------------------------------------

module number_to_word_tokens_test;
  import ntw_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [SepW-1:0]  sep;
    logic             err;
    logic             last;
  } token_t;

  class reading_board;
    token_t      expected_words_q[$];
    token_t      reading_q[$];
    int unsigned fail_count = 0;

    function void push_word(logic [WordW-1:0] word, logic [SepW-1:0] sep);
      token_t t;
      t.word = word;
      t.sep  = (reading_q.size() == 0) ? SepNone : sep;
      t.err  = 1'b0;
      t.last = 1'b0;
      reading_q.push_back(t);
    endfunction

    function void note_number(logic [ValueW-1:0] value);
      logic [ValueW-1:0] rest;
      logic [9:0]        grp [NumGroups];
      logic [9:0]        rem;
      token_t            t;
      reading_q.delete();
      if (value > MaxValue) begin
        t.word = TokZero;
        t.sep  = SepNone;
        t.err  = 1'b1;
        t.last = 1'b0;
        reading_q.push_back(t);
      end else if (value == '0) begin
        push_word(TokZero, SepNone);
      end else begin
        rest = value;
        for (int g = 0; g < NumGroups; g++) begin
          grp[g] = 10'(rest % 1000);
          rest   = rest / 1000;
        end
        for (int g = NumGroups - 1; g >= 0; g--) begin
          if (grp[g] != 0) begin
            rem = grp[g] % 100;
            if (grp[g] >= 100) begin
              push_word(WordW'(grp[g] / 100), SepSpace);
              push_word(TokHundred, SepSpace);
            end
            if (rem >= 20) begin
              push_word(TokTensBase + WordW'(rem / 10), SepSpace);
              if (rem % 10 != 0) push_word(WordW'(rem % 10), SepHyphen);
            end else if (rem != 0) begin
              push_word(WordW'(rem), SepSpace);
            end
            case (g)
              3: push_word(TokBillion, SepSpace);
              2: push_word(TokMillion, SepSpace);
              1: push_word(TokThousand, SepSpace);
              default: ;
            endcase
          end
        end
      end
      t = reading_q.pop_back();
      t.last = 1'b1;
      reading_q.push_back(t);
      expected_words_q = {expected_words_q, reading_q};
    endfunction

    function void check_word(token_t got);
      token_t want;
      if (expected_words_q.size() == 0) begin
        $display("%0t: unexpected word, actual word=%0d sep=%0d err=%0b last=%0b",
                 $time, got.word, got.sep, got.err, got.last);
        fail_count++;
        return;
      end
      want = expected_words_q.pop_front();
      if (got.err != want.err || got.last != want.last ||
          got.word != want.word || got.sep != want.sep) begin
        $display({"%0t: mismatch, expected word=%0d sep=%0d err=%0b last=%0b,",
                  " actual word=%0d sep=%0d err=%0b last=%0b"},
                 $time, want.word, want.sep, want.err, want.last,
                 got.word, got.sep, got.err, got.last);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [WordW-1:0]  word_o;
  logic [SepW-1:0]   separator_o;
  logic              range_error_o;
  logic              last_word_o;

  reading_board board = new();

  logic [ValueW-1:0] directed_values [24] = '{
    40'd0, 40'd1, 40'd10, 40'd19, 40'd20, 40'd21, 40'd99, 40'd100,
    40'd101, 40'd115, 40'd999, 40'd1000, 40'd1001, 40'd7000000,
    40'd1000000000, 40'd12345678901, 40'd20020020020, 40'd100000100000,
    40'd900000000019, 40'd999999999999, 40'd1000000000000,
    40'hFF_FFFF_FFFF, 40'h80_0000_0000, 40'd80
  };

  number_to_word_tokens uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .word_o,
    .separator_o,
    .range_error_o,
    .last_word_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_number(input logic [ValueW-1:0] v, input logic allow_gap);
    if (allow_gap && $urandom_range(99, 0) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_number(v);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (board.expected_words_q.size() != 0);
  endtask

  initial begin
    logic [ValueW-1:0] v;
    int unsigned       sel;
    int unsigned       pick;
    int unsigned       grp;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    value_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_values[i]) send_number(directed_values[i], 1'b1);
    for (int n = 0; n < 460; n++) begin
      if (n == 300) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      sel = $urandom_range(99, 0);
      if (sel < 10) begin
        v = {8'($urandom_range(255, 0)), $urandom()};
      end else if (sel < 18) begin
        v = MaxValue + 40'd1 +
            ({8'($urandom_range(255, 0)), $urandom()} % (40'hFF_FFFF_FFFF - MaxValue));
      end else begin
        v = '0;
        for (int g = 0; g < NumGroups; g++) begin
          pick = $urandom_range(99, 0);
          if (pick < 25) grp = 0;
          else if (pick < 40) grp = $urandom_range(19, 1);
          else if (pick < 55) grp = 10 * $urandom_range(9, 1);
          else if (pick < 65) grp = 100 * $urandom_range(9, 1) + $urandom_range(19, 0);
          else grp = $urandom_range(999, 0);
          v = v * 40'd1000 + 40'(grp);
        end
      end
      send_number(v, !(n >= 150 && n < 250));
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("[number_to_word_tokens] OK");
    end else begin
      $display("[number_to_word_tokens] ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned cycle;
    token_t      got;
    cycle = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.word = word_o;
        got.sep  = separator_o;
        got.err  = range_error_o;
        got.last = last_word_o;
        board.check_word(got);
      end
      if (rst_ni) cycle++;
      // hold off long enough to back up the block; later run without gaps
      if (cycle >= 1200 && cycle < 1600) out_ready_i <= 1'b0;
      else if (cycle >= 4000 && cycle < 6000) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(99, 0) >= 12);
    end
  end

  initial begin
    #2000000;
    $display("[number_to_word_tokens] ERROR");
    $finish;
  end

endmodule
